/* rtl/core/lhte_pkg.sv */
`timescale 1ns / 1ps
package lhte_pkg;

	// default sizes
	localparam int POOL_ENTRIES_DEF = 1024;
	localparam int MAX_BUCKETS_DEF  = 1024;
	localparam int KEY_BITS_DEF     = 64;
	localparam int HASH_BITS_DEF    = 32;

	// operation codes
	localparam logic [1:0] FUNC_FIND   = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_POOL_FULL = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_FILL_FACTOR = 2'd0;
	localparam logic [1:0] REG_GROW_ENABLE = 2'd1;
	localparam logic [1:0] REG_INIT_SIZE   = 2'd2;

	// register reset values
	localparam logic [7:0] FILL_FACTOR_RST = 8'd1;
	localparam logic [3:0] INIT_SIZE_RST   = 4'd4;

endpackage

/* rtl/core/linear_hash_table_engine_unit.sv */
`timescale 1ns / 1ps
// Chained hash table engine with linear-hashing growth. Raise start for one cycle while
// busy is low; the word is taken at that edge unless cfg_we is also high, which wins, and
// busy stays high until done pulses for one cycle with status, entry_index and list_count.
// The receiver cannot stall: the result stays on those outputs until the next done. An
// operation reads the bucket head and walks the chain in the bucket RAM and entry RAM,
// one entry per cycle, limited by the single read port of each memory; an insert then
// takes and links a free entry, a remove unlinks the entry and frees it, and an insert
// that adds a bucket first walks the old chain being split. After reset and after every
// write of initial_size_log2 the bucket head and entry link memories are swept with busy
// high; configuration writes go in only while busy is low.
module linear_hash_table_engine_unit #(
	parameter int POOL_ENTRIES = lhte_pkg::POOL_ENTRIES_DEF,
	parameter int MAX_BUCKETS  = lhte_pkg::MAX_BUCKETS_DEF,
	parameter int KEY_BITS     = lhte_pkg::KEY_BITS_DEF,
	parameter int HASH_BITS    = lhte_pkg::HASH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [KEY_BITS-1:0]  key,
	input  logic [HASH_BITS-1:0] hash,
	output logic                 done,
	output logic [2:0]           status,
	output logic [9:0]           entry_index,
	output logic [10:0]          list_count
);

	localparam int PW  = $clog2(POOL_ENTRIES + 1);
	localparam int IW  = $clog2(POOL_ENTRIES);
	localparam int BW  = $clog2(MAX_BUCKETS + 1);
	localparam int BAW = $clog2(MAX_BUCKETS);
	localparam int LOG_MAX = $clog2(MAX_BUCKETS + 1) - 1;
	localparam int SWEEP = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
	localparam int SW  = $clog2(SWEEP);
	localparam int HKW = HASH_BITS + KEY_BITS;
	localparam int PRW = 8 + BW;
	localparam int CMW = PRW + PW;
	localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_G0   = 4'd2;
	localparam logic [3:0] S_G1   = 4'd3;
	localparam logic [3:0] S_G2   = 4'd4;
	localparam logic [3:0] S_G3   = 4'd5;
	localparam logic [3:0] S_G4   = 4'd6;
	localparam logic [3:0] S_L0   = 4'd7;
	localparam logic [3:0] S_L1   = 4'd8;
	localparam logic [3:0] S_L2   = 4'd9;
	localparam logic [3:0] S_A0   = 4'd10;
	localparam logic [3:0] S_A1   = 4'd11;
	localparam logic [3:0] S_A2   = 4'd12;
	localparam logic [3:0] S_R0   = 4'd13;
	localparam logic [3:0] S_R1   = 4'd14;

	logic [3:0]           state_q;
	logic [SW-1:0]        sweep_q;
	logic [7:0]           fill_q;
	logic                 grow_en_q;
	logic [BW-1:0]        bcount_q;
	logic [BW-1:0]        low_q;
	logic [BW-1:0]        high_q;
	logic [PW-1:0]        free_q;
	logic [PW-1:0]        items_q;
	logic [1:0]           func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [PW-1:0]        cur_q;
	logic [PW-1:0]        prev_q;
	logic [PW-1:0]        nxt_q;
	logic [PW-1:0]        otail_q;
	logic [PW-1:0]        ntail_q;
	logic [BAW-1:0]       b_q;
	logic [BAW-1:0]       ob_q;
	logic [BAW-1:0]       nb_q;
	logic [PW-1:0]        e_q;

	logic                 bh_we;
	logic [BAW-1:0]       bh_waddr;
	logic [PW-1:0]        bh_wdata;
	logic [BAW-1:0]       bh_raddr;
	logic [PW-1:0]        bh_rdata;
	logic                 nx_we;
	logic [IW-1:0]        nx_waddr;
	logic [PW-1:0]        nx_wdata;
	logic [IW-1:0]        nx_raddr;
	logic [PW-1:0]        nx_rdata;
	logic                 hk_we;
	logic [HKW-1:0]       hk_rdata;

	logic [PRW-1:0]       limit;
	logic                 want_grow;
	logic                 split_old;
	logic                 match;
	logic [BAW-1:0]       look_b;
	logic [BW-1:0]        grown;

	// bucket of a hash under the given masks and count
	function automatic logic [BAW-1:0] bucket_of(input logic [HASH_BITS-1:0] h,
			input logic [BW-1:0] hi, input logic [BW-1:0] lo, input logic [BW-1:0] cnt);
		logic [BW-1:0] b;
		b = BW'(h) & hi;
		if (b > cnt - BW'(1)) begin
			b = b & lo;
		end
		if (b >= cnt) begin
			b = '0;
		end
		return BAW'(b);
	endfunction

	// initial bucket count from the size register, saturated
	function automatic logic [BW-1:0] size_of(input logic [3:0] lg);
		logic [3:0] s;
		s = (32'(lg) > LOG_MAX) ? 4'(LOG_MAX) : lg;
		return BW'(1) << s;
	endfunction

	assign limit     = PRW'(fill_q) * PRW'(bcount_q);
	assign want_grow = (func == lhte_pkg::FUNC_INSERT) && grow_en_q &&
		(bcount_q < BW'(MAX_BUCKETS)) && (CMW'(items_q) > CMW'(limit));
	assign split_old = bucket_of(hk_rdata[HKW-1 -: HASH_BITS], high_q, low_q, bcount_q) == ob_q;
	assign match     = hk_rdata == {hash_q, key_q};
	assign look_b    = bucket_of(hash_q, high_q, low_q, bcount_q);
	assign grown     = bcount_q + BW'(1);
	assign busy      = state_q != S_IDLE;

	// memory port control
	always_comb begin
		bh_we    = 1'b0;
		bh_waddr = '0;
		bh_wdata = NIL;
		bh_raddr = '0;
		nx_we    = 1'b0;
		nx_waddr = '0;
		nx_wdata = NIL;
		nx_raddr = '0;
		hk_we    = 1'b0;
		case (state_q)
			S_CLR: begin
				bh_we    = 32'(sweep_q) < MAX_BUCKETS;
				bh_waddr = BAW'(sweep_q);
				nx_we    = 32'(sweep_q) < POOL_ENTRIES;
				nx_waddr = IW'(sweep_q);
				nx_wdata = PW'(sweep_q) + PW'(1);
			end
			S_G0: begin
				bh_raddr = ob_q;
				bh_we    = 1'b1;
				bh_waddr = nb_q;
			end
			S_G1: begin
				bh_we    = 1'b1;
				bh_waddr = ob_q;
				nx_raddr = IW'(bh_rdata);
			end
			S_G2: begin
				nx_raddr = IW'(nx_rdata);
				if (split_old) begin
					if (otail_q == NIL) begin
						bh_we    = 1'b1;
						bh_waddr = ob_q;
						bh_wdata = cur_q;
					end else begin
						nx_we    = 1'b1;
						nx_waddr = IW'(otail_q);
						nx_wdata = cur_q;
					end
				end else begin
					if (ntail_q == NIL) begin
						bh_we    = 1'b1;
						bh_waddr = nb_q;
						bh_wdata = cur_q;
					end else begin
						nx_we    = 1'b1;
						nx_waddr = IW'(ntail_q);
						nx_wdata = cur_q;
					end
				end
			end
			S_G3: begin
				nx_we    = otail_q != NIL;
				nx_waddr = IW'(otail_q);
			end
			S_G4: begin
				nx_we    = ntail_q != NIL;
				nx_waddr = IW'(ntail_q);
			end
			S_L0: begin
				bh_raddr = look_b;
			end
			S_L1: begin
				nx_raddr = IW'(bh_rdata);
			end
			S_L2: begin
				nx_raddr = IW'(nx_rdata);
			end
			S_A0: begin
				nx_raddr = IW'(free_q);
			end
			S_A1: begin
				nx_we    = 1'b1;
				nx_waddr = IW'(free_q);
				hk_we    = 1'b1;
			end
			S_A2: begin
				if (prev_q == NIL) begin
					bh_we    = 1'b1;
					bh_waddr = b_q;
					bh_wdata = e_q;
				end else begin
					nx_we    = 1'b1;
					nx_waddr = IW'(prev_q);
					nx_wdata = e_q;
				end
			end
			S_R0: begin
				if (prev_q == NIL) begin
					bh_we    = 1'b1;
					bh_waddr = b_q;
					bh_wdata = nxt_q;
				end else begin
					nx_we    = 1'b1;
					nx_waddr = IW'(prev_q);
					nx_wdata = nxt_q;
				end
			end
			S_R1: begin
				nx_we    = 1'b1;
				nx_waddr = IW'(cur_q);
				nx_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	lhte_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_bucket_head (
		.clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
		.raddr(bh_raddr), .rdata(bh_rdata)
	);

	lhte_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_entry_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(nx_raddr), .rdata(nx_rdata)
	);

	// hash and key share one address, so one memory
	lhte_ram #(.WIDTH(HKW), .DEPTH(POOL_ENTRIES)) u_entry_hk (
		.clk(clk), .we(hk_we), .waddr(nx_waddr), .wdata({hash_q, key_q}),
		.raddr(nx_raddr), .rdata(hk_rdata)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			sweep_q   <= '0;
			fill_q    <= lhte_pkg::FILL_FACTOR_RST;
			grow_en_q <= 1'b0;
			bcount_q  <= size_of(lhte_pkg::INIT_SIZE_RST);
			low_q     <= size_of(lhte_pkg::INIT_SIZE_RST) - BW'(1);
			high_q    <= (size_of(lhte_pkg::INIT_SIZE_RST) << 1) - BW'(1);
			free_q    <= '0;
			items_q   <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						case (cfg_index)
							lhte_pkg::REG_FILL_FACTOR: fill_q <= cfg_data;
							lhte_pkg::REG_GROW_ENABLE: grow_en_q <= cfg_data[0];
							lhte_pkg::REG_INIT_SIZE: begin
								bcount_q <= size_of(cfg_data[3:0]);
								low_q    <= size_of(cfg_data[3:0]) - BW'(1);
								high_q   <= (size_of(cfg_data[3:0]) << 1) - BW'(1);
								free_q   <= '0;
								items_q  <= '0;
								sweep_q  <= '0;
								state_q  <= S_CLR;
							end
							default: begin
							end
						endcase
					end else if (start) begin
						func_q <= func;
						key_q  <= key;
						hash_q <= hash;
						if (want_grow) begin
							nb_q     <= BAW'(bcount_q);
							ob_q     <= BAW'(bcount_q & low_q);
							bcount_q <= grown;
							if (grown > high_q) begin
								low_q  <= high_q;
								high_q <= grown | high_q;
							end
							state_q <= S_G0;
						end else begin
							state_q <= S_L0;
						end
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + SW'(1);
					if (32'(sweep_q) == SWEEP - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_G0: state_q <= S_G1;
				S_G1: begin
					cur_q   <= bh_rdata;
					otail_q <= NIL;
					ntail_q <= NIL;
					state_q <= (bh_rdata == NIL) ? S_L0 : S_G2;
				end
				S_G2: begin
					if (split_old) begin
						otail_q <= cur_q;
					end else begin
						ntail_q <= cur_q;
					end
					cur_q <= nx_rdata;
					if (nx_rdata == NIL) begin
						state_q <= S_G3;
					end
				end
				S_G3: state_q <= S_G4;
				S_G4: state_q <= S_L0;
				S_L0: begin
					b_q     <= look_b;
					state_q <= S_L1;
				end
				S_L1: begin
					cur_q  <= bh_rdata;
					prev_q <= NIL;
					if (bh_rdata != NIL) begin
						state_q <= S_L2;
					end else if (func_q == lhte_pkg::FUNC_INSERT && free_q != NIL) begin
						state_q <= S_A0;
					end else begin
						done        <= 1'b1;
						status      <= (func_q == lhte_pkg::FUNC_INSERT) ?
							lhte_pkg::ST_POOL_FULL : lhte_pkg::ST_NOT_FOUND;
						entry_index <= '0;
						list_count  <= 11'(bcount_q);
						state_q     <= S_IDLE;
					end
				end
				S_L2: begin
					if (match) begin
						nxt_q <= nx_rdata;
						if (func_q == lhte_pkg::FUNC_REMOVE) begin
							state_q <= S_R0;
						end else begin
							done        <= 1'b1;
							status      <= lhte_pkg::ST_HIT;
							entry_index <= 10'(cur_q);
							list_count  <= 11'(bcount_q);
							state_q     <= S_IDLE;
						end
					end else begin
						prev_q <= cur_q;
						cur_q  <= nx_rdata;
						if (nx_rdata == NIL) begin
							if (func_q == lhte_pkg::FUNC_INSERT && free_q != NIL) begin
								state_q <= S_A0;
							end else begin
								done        <= 1'b1;
								status      <= (func_q == lhte_pkg::FUNC_INSERT) ?
									lhte_pkg::ST_POOL_FULL : lhte_pkg::ST_NOT_FOUND;
								entry_index <= '0;
								list_count  <= 11'(bcount_q);
								state_q     <= S_IDLE;
							end
						end
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					e_q     <= free_q;
					free_q  <= nx_rdata;
					items_q <= items_q + PW'(1);
					state_q <= S_A2;
				end
				S_A2: begin
					done        <= 1'b1;
					status      <= lhte_pkg::ST_INSERTED;
					entry_index <= 10'(e_q);
					list_count  <= 11'(bcount_q);
					state_q     <= S_IDLE;
				end
				S_R0: state_q <= S_R1;
				S_R1: begin
					free_q      <= cur_q;
					items_q     <= items_q - PW'(1);
					done        <= 1'b1;
					status      <= lhte_pkg::ST_REMOVED;
					entry_index <= 10'(cur_q);
					list_count  <= 11'(bcount_q);
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/lhte_ram.sv */
`timescale 1ns / 1ps
module lhte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
